// ===== design/gtp_pkg.sv =====
// shared types, constants and tables of the go-to-pose controller
`default_nettype none
package gtp_pkg;

   localparam int unsigned MAX_LIN_DEF = 65536;
   localparam int unsigned MAX_ANG_DEF = 65536;
   localparam int unsigned CORDIC_ITER_DEF = 16;

   localparam logic [31:0] PI_Q29 = 32'd1686629713;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;

   localparam logic [1:0] STAT_INIT = 2'd0;
   localparam logic [1:0] STAT_RUN  = 2'd1;
   localparam logic [1:0] STAT_DONE = 2'd2;
   localparam logic [1:0] STAT_TERM = 2'd3;

   localparam logic [2:0] REG_GOAL_X   = 3'd0;
   localparam logic [2:0] REG_GOAL_Y   = 3'd1;
   localparam logic [2:0] REG_GOAL_HD  = 3'd2;
   localparam logic [2:0] REG_DIST_TOL = 3'd3;
   localparam logic [2:0] REG_ANG_TOL  = 3'd4;
   localparam logic [2:0] REG_DIST_GN  = 3'd5;
   localparam logic [2:0] REG_ANG_GN   = 3'd6;
   localparam logic [2:0] REG_REL      = 3'd7;

   typedef enum logic [2:0] {
      PH_IDLE, PH_HEADING, PH_TRAVELLING, PH_REACHED, PH_DONE, PH_STOPPED
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_NORM, ST_CORDIC, ST_TURN, ST_TURN_PI, ST_TURN_OUT,
      ST_SQ_X, ST_SQ_Y, ST_SQ_SUM, ST_SQRT, ST_LIN_OUT, ST_EMIT
   } state_type;

   typedef struct packed {
      logic signed [31:0] goal_x;
      logic signed [31:0] goal_y;
      logic signed [15:0] goal_hd;
      logic [30:0]        dist_tol;
      logic [14:0]        ang_tol;
      logic [15:0]        dist_gain;
      logic [15:0]        ang_gain;
      logic               rel;
   } cfg_type;

   typedef struct packed {
      logic [15:0]        hd;
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic [31:0]        ang;
      logic [5:0]         cnt;
      logic [15:0]        tgt;
      logic [63:0]        sq;
      logic [63:0]        n;
      logic [63:0]        res;
      logic [63:0]        bit_w;
      logic [1:0]         sh;
      logic [31:0]        lin;
      logic [31:0]        rot;
      logic [1:0]         stat;
   } dp_type;

   // arctangent of 2^-i as a 32-bit binary angle
   function automatic logic [31:0] atan_lut(input logic [4:0] idx);
      logic [31:0] v;
      unique case (idx)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10680862;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670675;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         5'd24: v = 32'd41;
         5'd25: v = 32'd20;
         5'd26: v = 32'd10;
         5'd27: v = 32'd5;
         5'd28: v = 32'd3;
         5'd29: v = 32'd1;
         5'd30: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== design/gtp_mul.sv =====
// shared unsigned multiplier with registered product
`default_nettype none
module gtp_mul
   import gtp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic [34:0] mul_a,
   input  wire logic [31:0] mul_b,
   output logic [66:0]      mul_p
);
   logic [66:0] p_ff;
   logic [66:0] p_in;

   assign p_in = 67'(mul_a) * 67'(mul_b);

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign mul_p = p_ff;
endmodule
`default_nettype wire

// ===== design/go_to_pose_controller.sv =====
// go-to-pose controller: turn, drive, final turn, with iterative cordic and square root
// sequence: start and terminate requests and ticks in the idle, done or stopped phase go
// straight to the emit state; a heading tick normalizes, runs the cordic and computes the
// turn speed, a final turn tick only the turn speed; a travel tick squares, sums and roots
// one request in flight at a time; a finished result waits in the output register
// synchronous active-high reset: phase idle, origin zero, registers at defaults, no result
`default_nettype none
module go_to_pose_controller
   import gtp_pkg::*;
#(
   parameter int unsigned MAX_LINEAR_SPEED  = MAX_LIN_DEF,
   parameter int unsigned MAX_ANGULAR_SPEED = MAX_ANG_DEF,
   parameter int unsigned CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [79:0] req_tdata,   // pose_x, pose_y, pose_heading
   input  wire logic [1:0]  req_tuser,   // op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // linear_speed, angular_speed
   output logic [1:0]       rsp_tuser,   // status
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   localparam logic [5:0]  LAST_ITER = 6'(CORDIC_ITERATIONS - 1);
   localparam logic [30:0] MAX_ANG   = 31'(MAX_ANGULAR_SPEED);
   localparam logic [58:0] MAX_LIN   = 59'(MAX_LINEAR_SPEED);

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   cfg_type   cfg_ff, cfg_in;
   dp_type    dp_ff, dp_in;
   logic signed [31:0] org_x_ff, org_x_in, org_y_ff, org_y_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_stat_ff, rsp_stat_in;

   logic [34:0] mul_a;
   logic [31:0] mul_b;
   logic [66:0] mul_p;

   logic accept, rsp_free;
   logic signed [31:0] px, py;
   logic [15:0] alpha, mag;
   logic        aligned;
   logic [63:0] axn, ayn;
   logic        nzero, nlow;
   logic signed [63:0] xs, ys;
   logic        ypos, cordic_last;
   logic [31:0] ang_next;
   logic [33:0] adx, ady, aor;
   logic [1:0]  sh;
   logic [30:0] axs, ays;
   logic [63:0] t_sum, res_next;
   logic        ge, sqrt_last;
   logic [33:0] r_val;
   logic        r_small;
   logic [66:0] sp_sum, v_sum;
   logic [30:0] sp;
   logic [58:0] v;

   gtp_mul u_mul (.clock(clock), .mul_a(mul_a), .mul_b(mul_b), .mul_p(mul_p));

   assign accept   = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign px = req_tdata[31:0];
   assign py = req_tdata[63:32];

   // turn error
   assign alpha   = dp_ff.tgt - dp_ff.hd;
   assign mag     = alpha[15] ? 16'(-alpha) : alpha;
   assign aligned = mag <= {1'b0, cfg_ff.ang_tol};

   // cordic normalize and step
   assign axn   = dp_ff.x[63] ? 64'(-dp_ff.x) : 64'(dp_ff.x);
   assign ayn   = dp_ff.y[63] ? 64'(-dp_ff.y) : 64'(dp_ff.y);
   assign nzero = (dp_ff.x == 64'sd0) && (dp_ff.y == 64'sd0);
   assign nlow  = (axn[63:59] == 5'd0) && (ayn[63:59] == 5'd0);
   assign xs    = dp_ff.x >>> dp_ff.cnt[4:0];
   assign ys    = dp_ff.y >>> dp_ff.cnt[4:0];
   assign ypos  = !dp_ff.y[63] && (dp_ff.y != 64'sd0);
   assign ang_next = ypos ? dp_ff.ang + atan_lut(dp_ff.cnt[4:0])
                          : dp_ff.ang - atan_lut(dp_ff.cnt[4:0]);
   assign cordic_last = dp_ff.cnt == LAST_ITER;

   // distance prescale so both legs fit 31 bits
   assign adx = dp_ff.dx[33] ? 34'(-dp_ff.dx) : 34'(dp_ff.dx);
   assign ady = dp_ff.dy[33] ? 34'(-dp_ff.dy) : 34'(dp_ff.dy);
   assign aor = adx | ady;
   assign sh  = aor[32] ? 2'd2 : (aor[31] ? 2'd1 : 2'd0);
   assign axs = 31'(adx >> sh);
   assign ays = 31'(ady >> sh);

   // one root digit per cycle
   assign t_sum     = dp_ff.res + dp_ff.bit_w;
   assign ge        = dp_ff.n >= t_sum;
   assign res_next  = ge ? (dp_ff.res >> 1) + dp_ff.bit_w : dp_ff.res >> 1;
   assign sqrt_last = dp_ff.cnt == 6'd31;
   assign r_val     = 34'(res_next) << dp_ff.sh;
   assign r_small   = r_val < {3'd0, cfg_ff.dist_tol};

   assign sp_sum = mul_p + (67'd1 << 35);
   assign sp     = sp_sum[66:36];
   assign v_sum  = mul_p + 67'd128;
   assign v      = v_sum[66:8];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser != OP_TICK) state_in = ST_EMIT;
               else if (phase_ff == PH_HEADING) state_in = ST_NORM;
               else if (phase_ff == PH_TRAVELLING) state_in = ST_SQ_X;
               else if (phase_ff == PH_REACHED) state_in = ST_TURN;
               else state_in = ST_EMIT;
            end
         end
         ST_NORM: begin
            if (nzero) state_in = ST_TURN;
            else if (!nlow) state_in = ST_CORDIC;
         end
         ST_CORDIC:   if (cordic_last) state_in = ST_TURN;
         ST_TURN:     state_in = aligned ? ST_EMIT : ST_TURN_PI;
         ST_TURN_PI:  state_in = ST_TURN_OUT;
         ST_TURN_OUT: state_in = ST_EMIT;
         ST_SQ_X:     state_in = ST_SQ_Y;
         ST_SQ_Y:     state_in = ST_SQ_SUM;
         ST_SQ_SUM:   state_in = ST_SQRT;
         ST_SQRT:     if (sqrt_last) state_in = r_small ? ST_EMIT : ST_LIN_OUT;
         ST_LIN_OUT:  state_in = ST_EMIT;
         ST_EMIT:     if (rsp_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer: handshake and multiplier operands
   always_comb begin
      req_tready = 1'b0;
      mul_a = 35'd0;
      mul_b = 32'd0;
      unique case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_TURN: begin
            mul_a = 35'(mag);
            mul_b = 32'(cfg_ff.ang_gain);
         end
         ST_TURN_PI: begin
            mul_a = 35'(mul_p[31:0]);
            mul_b = PI_Q29;
         end
         ST_SQ_X: begin
            mul_a = 35'(axs);
            mul_b = 32'(axs);
         end
         ST_SQ_Y: begin
            mul_a = 35'(ays);
            mul_b = 32'(ays);
         end
         ST_SQRT: begin
            mul_a = 35'(r_val);
            mul_b = 32'(cfg_ff.dist_gain);
         end
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      dp_in    = dp_ff;
      phase_in = phase_ff;
      org_x_in = org_x_ff;
      org_y_in = org_y_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dp_in.hd   = req_tdata[79:64];
               dp_in.dx   = 34'(org_x_ff) + 34'(cfg_ff.goal_x) - 34'(px);
               dp_in.dy   = 34'(org_y_ff) + 34'(cfg_ff.goal_y) - 34'(py);
               dp_in.x    = 64'(dp_in.dx);
               dp_in.y    = 64'(dp_in.dy);
               dp_in.ang  = 32'd0;
               dp_in.cnt  = 6'd0;
               dp_in.tgt  = cfg_ff.goal_hd;
               dp_in.lin  = 32'd0;
               dp_in.rot  = 32'd0;
               dp_in.stat = STAT_RUN;
               if (req_tuser == OP_START) begin
                  org_x_in   = cfg_ff.rel ? px : 32'sd0;
                  org_y_in   = cfg_ff.rel ? py : 32'sd0;
                  phase_in   = PH_HEADING;
                  dp_in.stat = STAT_INIT;
               end else if (req_tuser != OP_TICK) begin
                  phase_in   = PH_STOPPED;
                  dp_in.stat = STAT_TERM;
               end else begin
                  unique case (phase_ff)
                     PH_DONE:    dp_in.stat = STAT_DONE;
                     PH_STOPPED: dp_in.stat = STAT_TERM;
                     PH_IDLE:    dp_in.stat = STAT_INIT;
                     default: ;
                  endcase
               end
            end
         end
         ST_NORM: begin
            if (nzero) begin
               dp_in.tgt = 16'd0;
            end else if (nlow) begin
               dp_in.x = dp_ff.x <<< 1;
               dp_in.y = dp_ff.y <<< 1;
            end else if (dp_ff.x[63]) begin
               // fold into the right half plane
               dp_in.x   = -dp_ff.x;
               dp_in.y   = -dp_ff.y;
               dp_in.ang = 32'h8000_0000;
            end
         end
         ST_CORDIC: begin
            dp_in.x   = ypos ? dp_ff.x + ys : dp_ff.x - ys;
            dp_in.y   = ypos ? dp_ff.y - xs : dp_ff.y + xs;
            dp_in.ang = ang_next;
            dp_in.cnt = dp_ff.cnt + 6'd1;
            if (cordic_last) dp_in.tgt = 16'((ang_next + 32'h8000) >> 16);
         end
         ST_TURN: begin
            if (aligned) begin
               if (phase_ff == PH_HEADING) begin
                  phase_in = PH_TRAVELLING;
               end else begin
                  phase_in   = PH_DONE;
                  dp_in.stat = STAT_DONE;
               end
            end
         end
         ST_TURN_OUT: begin
            dp_in.rot = (sp > MAX_ANG) ? 32'(MAX_ANG) : 32'(sp);
            if (alpha[15]) dp_in.rot = -dp_in.rot;
         end
         ST_SQ_Y: begin
            dp_in.sq = mul_p[63:0];
            dp_in.sh = sh;
         end
         ST_SQ_SUM: begin
            dp_in.n     = dp_ff.sq + mul_p[63:0];
            dp_in.res   = 64'd0;
            dp_in.bit_w = 64'd1 << 62;
            dp_in.cnt   = 6'd0;
         end
         ST_SQRT: begin
            if (ge) dp_in.n = dp_ff.n - t_sum;
            dp_in.res   = res_next;
            dp_in.bit_w = dp_ff.bit_w >> 2;
            dp_in.cnt   = dp_ff.cnt + 6'd1;
            if (sqrt_last && r_small) phase_in = PH_REACHED;
         end
         ST_LIN_OUT: dp_in.lin = (v > MAX_LIN) ? 32'(MAX_LIN) : 32'(v);
         default: ;
      endcase
   end

   // result register and configuration writes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_stat_in  = rsp_stat_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (state_ff == ST_EMIT && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {dp_ff.rot, dp_ff.lin};
         rsp_stat_in  = dp_ff.stat;
      end
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_GOAL_X:   cfg_in.goal_x    = csr_wdata;
            REG_GOAL_Y:   cfg_in.goal_y    = csr_wdata;
            REG_GOAL_HD:  cfg_in.goal_hd   = csr_wdata[15:0];
            REG_DIST_TOL: cfg_in.dist_tol  = csr_wdata[30:0];
            REG_ANG_TOL:  cfg_in.ang_tol   = csr_wdata[14:0];
            REG_DIST_GN:  cfg_in.dist_gain = csr_wdata[15:0];
            REG_ANG_GN:   cfg_in.ang_gain  = csr_wdata[15:0];
            REG_REL:      cfg_in.rel       = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_IDLE;
         org_x_ff     <= 32'sd0;
         org_y_ff     <= 32'sd0;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '{goal_x: 32'sd0, goal_y: 32'sd0, goal_hd: 16'sd0,
                           dist_tol: 31'd6554, ang_tol: 15'd1043,
                           dist_gain: 16'd256, ang_gain: 16'd256, rel: 1'b0};
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         org_x_ff     <= org_x_in;
         org_y_ff     <= org_y_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
      dp_ff       <= dp_in;
      rsp_data_ff <= rsp_data_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_stat_ff;
endmodule
`default_nettype wire
